/* rtl/core/smbr_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smbr_pkg
// shared types, codes and constants of the bounded random generator
// ---------------------------------------------------------------------------
package smbr_pkg;

  localparam logic [63:0] MIX_MUL_A   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GAMMA_RESET = 64'h9e3779b97f4a7c15;
  localparam int unsigned MAX_DRAWS   = 256;
  localparam int unsigned CNT_W       = $clog2(MAX_DRAWS) + 1;
  localparam int unsigned MIX_SHIFT   = 33;

  localparam logic [2:0] KIND_RAW64   = 3'd0;
  localparam logic [2:0] KIND_RAW32   = 3'd1;
  localparam logic [2:0] KIND_RANGE64 = 3'd2;
  localparam logic [2:0] KIND_RANGE32 = 3'd3;
  localparam logic [2:0] KIND_TOPBITS = 3'd4;
  localparam logic [2:0] KIND_BOOL    = 3'd5;

  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_SEED  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_DRAW, S_MUL1, S_MUL2, S_EVAL, S_DIV, S_CHECK, S_OUT
  } smbr_state_t;

  typedef enum logic [2:0] {
    RES_SIMPLE, RES_MASK, RES_DIRECT, RES_LO, RES_REM
  } smbr_res_t;

  typedef struct packed {
    logic      load;
    logic      draw;
    logic      count;
    logic      mix2;
    logic      div_start;
    logic      finish;
    smbr_res_t res_sel;
    logic      publish;
  } smbr_cmd_t;

  typedef struct packed {
    logic skip;
    logic is_range;
    logic pow2;
    logic fits;
    logic in_range;
    logic accept;
    logic cnt_max;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } smbr_status_t;

  function automatic logic [63:0] sext32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/smbr_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smbr_ctrl
// request sequencer: draw, mix, reduce and hand over one word per request
// ---------------------------------------------------------------------------
module smbr_ctrl
  import smbr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire smbr_status_t st,
  output smbr_cmd_t         cmd
);

  smbr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = st.skip ? S_OUT : S_DRAW;
      end
      S_DRAW: state_nxt = S_MUL1;
      S_MUL1: begin
        if (st.mul_done) state_nxt = S_MUL2;
      end
      S_MUL2: begin
        if (st.mul_done) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!st.is_range || st.pow2) state_nxt = S_OUT;
        else if (st.fits) state_nxt = S_DIV;
        else if (st.in_range || st.cnt_max) state_nxt = S_OUT;
        else state_nxt = S_MUL1;
      end
      S_DIV: begin
        if (st.div_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.accept || st.cnt_max) state_nxt = S_OUT;
        else state_nxt = S_MUL1;
      end
      S_OUT: begin
        if (!st.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.res_sel = RES_SIMPLE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DRAW: cmd.draw = 1'b1;
      S_MUL1: cmd.mix2 = st.mul_done;
      S_MUL2: ;
      S_EVAL: begin
        if (!st.is_range) begin
          cmd.finish = 1'b1;
        end else if (st.pow2) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_MASK;
        end else if (st.fits) begin
          cmd.div_start = 1'b1;
        end else if (st.in_range) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_DIRECT;
        end else if (st.cnt_max) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_LO;
        end else begin
          cmd.draw  = 1'b1;
          cmd.count = 1'b1;
        end
      end
      S_DIV: ;
      S_CHECK: begin
        if (st.accept || st.cnt_max) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_REM;
        end else begin
          cmd.draw  = 1'b1;
          cmd.count = 1'b1;
        end
      end
      S_OUT: cmd.publish = !st.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/smbr_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smbr_datapath
// seed state, shared 32x32 multiplier, bit-serial remainder unit, result regs
// ---------------------------------------------------------------------------
module smbr_datapath
  import smbr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic [2:0]   in_kind,
  input  wire logic [63:0]  in_lo,
  input  wire logic [63:0]  in_hi,
  input  wire logic [5:0]   in_bits,
  input  wire smbr_cmd_t    cmd,
  output smbr_status_t      st,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_value,
  output logic              out_error
);

  logic [63:0] seed_r, gamma_r;
  logic [2:0]  kind_r;
  logic [5:0]  bits_r;
  logic [63:0] lo_r, hi_r, n_r;
  logic [CNT_W-1:0] cnt_r;

  logic [63:0] mul_a_r, mul_b_r, prod_r, acc_r;
  logic [1:0]  mul_ph_r;
  logic        mul_busy_r, mul_done_r;

  logic [63:0] u_r, dq_r, rem_r;
  logic [5:0]  div_cnt_r;
  logic        div_busy_r, div_done_r;

  logic [63:0] res_r;
  logic        err_r;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_error_r;

  // request decode on the input word
  logic        in_w32, in_is_range, in_empty;
  logic [63:0] in_mask, in_lo_m, in_hi_m;
  always_comb begin
    in_w32      = (in_kind == KIND_RANGE32);
    in_is_range = (in_kind == KIND_RANGE64) || in_w32;
    in_mask     = in_w32 ? 64'h0000_0000_ffff_ffff : '1;
    in_lo_m     = in_lo & in_mask;
    in_hi_m     = in_hi & in_mask;
    if (in_w32)
      in_empty = !((in_lo[31:0] ^ 32'h8000_0000) < (in_hi[31:0] ^ 32'h8000_0000));
    else
      in_empty = !((in_lo ^ 64'h8000_0000_0000_0000) < (in_hi ^ 64'h8000_0000_0000_0000));
  end

  // working-width helpers
  logic        w32, is_range;
  logic [63:0] wmask, sbit, m, d64, r, s_acc;
  logic        lt_lo, lt_hi;
  always_comb begin
    w32      = (kind_r == KIND_RANGE32);
    is_range = (kind_r == KIND_RANGE64) || w32;
    wmask    = w32 ? 64'h0000_0000_ffff_ffff : '1;
    sbit     = w32 ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
    m        = (n_r - 64'd1) & wmask;
    d64      = acc_r ^ (acc_r >> MIX_SHIFT);
    r        = w32 ? {32'd0, acc_r[63:32]} : d64;
    lt_lo    = (r ^ sbit) < (lo_r ^ sbit);
    lt_hi    = (r ^ sbit) < (hi_r ^ sbit);
    s_acc    = (u_r + m - rem_r) & wmask;
  end

  always_comb begin
    st          = '0;
    st.skip     = (in_kind > KIND_BOOL) || (in_is_range && in_empty);
    st.is_range = is_range;
    st.pow2     = ((n_r & m) == 64'd0);
    st.fits     = ((n_r & sbit) == 64'd0);
    st.in_range = !lt_lo && lt_hi;
    st.accept   = ((s_acc & sbit) == 64'd0);
    st.cnt_max  = (cnt_r >= CNT_W'(MAX_DRAWS));
    st.mul_done = mul_done_r;
    st.div_done = div_done_r;
    st.out_busy = out_valid_r && !out_tready;
  end

  // result selection
  logic [5:0]  bc_sat, shamt;
  logic [31:0] top32;
  logic [63:0] simple_v, range_v, range_m, res_nxt;
  always_comb begin
    bc_sat = (bits_r > 6'd32) ? 6'd32 : bits_r;
    shamt  = 6'd32 - bc_sat;
    top32  = d64[63:32] >> shamt[4:0];
    case (kind_r)
      KIND_RAW64:   simple_v = d64;
      KIND_RAW32:   simple_v = sext32(acc_r[63:32]);
      KIND_TOPBITS: simple_v = (bc_sat == 6'd0) ? 64'd0 : sext32(top32);
      KIND_BOOL:    simple_v = {63'd0, acc_r[63]};
      default:      simple_v = 64'd0;
    endcase
    case (cmd.res_sel)
      RES_MASK:   range_v = (r & m) + lo_r;
      RES_DIRECT: range_v = r;
      RES_LO:     range_v = lo_r;
      RES_REM:    range_v = rem_r + lo_r;
      default:    range_v = 64'd0;
    endcase
    range_m = range_v & wmask;
    if (cmd.res_sel == RES_SIMPLE) res_nxt = simple_v;
    else res_nxt = w32 ? sext32(range_m[31:0]) : range_m;
  end

  // seed and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      gamma_r <= GAMMA_RESET;
    end else begin
      if (cfg_we && cfg_index == CFG_GAMMA) gamma_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_SEED) seed_r <= cfg_wdata;
      else if (cmd.draw) seed_r <= seed_r + gamma_r;
    end
  end

  // request capture and draw count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= CNT_W'(1);
    end else if (cmd.count) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      bits_r <= in_bits;
      lo_r   <= in_lo_m;
      hi_r   <= in_hi_m;
      n_r    <= (in_hi_m - in_lo_m) & in_mask;
    end
  end

  // 64x64 low product from three 32x32 partial products
  logic [31:0] mop_a, mop_b;
  always_comb begin
    case (mul_ph_r)
      2'd1:    begin mop_a = mul_a_r[31:0];  mop_b = mul_b_r[63:32]; end
      2'd2:    begin mop_a = mul_a_r[63:32]; mop_b = mul_b_r[31:0];  end
      default: begin mop_a = mul_a_r[31:0];  mop_b = mul_b_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_ph_r   <= '0;
    end else begin
      mul_done_r <= mul_busy_r && (mul_ph_r == 2'd3);
      if (cmd.draw || cmd.mix2) begin
        mul_busy_r <= 1'b1;
        mul_ph_r   <= '0;
      end else if (mul_busy_r) begin
        mul_ph_r <= mul_ph_r + 2'd1;
        if (mul_ph_r == 2'd3) begin
          mul_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      mul_a_r <= seed_r ^ (seed_r >> MIX_SHIFT);
      mul_b_r <= MIX_MUL_A;
    end else if (cmd.mix2) begin
      mul_a_r <= acc_r ^ (acc_r >> MIX_SHIFT);
      mul_b_r <= MIX_MUL_B;
    end
    if (mul_busy_r) begin
      prod_r <= mop_a * mop_b;
      case (mul_ph_r)
        2'd1:    acc_r <= prod_r;
        2'd2:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
        2'd3:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
        default: ;
      endcase
    end
  end

  // restoring remainder, one quotient bit a cycle
  logic [63:0] div_try;
  always_comb div_try = {rem_r[62:0], dq_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      div_done_r <= div_busy_r && (div_cnt_r == 6'd63);
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd63) begin
          div_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      u_r   <= r >> 1;
      dq_r  <= r >> 1;
      rem_r <= '0;
    end else if (div_busy_r) begin
      dq_r  <= dq_r << 1;
      rem_r <= (div_try >= n_r) ? div_try - n_r : div_try;
    end
  end

  // result and output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= '0;
      err_r <= in_is_range && in_empty;
    end else if (cmd.finish) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_value_r <= res_r;
      out_error_r <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_error  = out_error_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy_r && div_busy_r))
    else $error("multiplier and remainder unit busy together");

  a_draw_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw |=> mul_busy_r)
    else $error("draw did not start the multiplier");

  a_seed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.draw && !cfg_we |=> $stable(seed_r))
    else $error("seed moved without a draw");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DRAWS))
    else $error("draw count beyond limit");

endmodule
`default_nettype wire

/* rtl/core/splitmix_bounded_random_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// splitmix_bounded_random_top
// weyl-sequence generator with murmur3 finaliser and bounded draws
// ---------------------------------------------------------------------------
// One request is handled at a time. A draw runs the two dependent 64-bit
// finaliser multiplies one after the other, each as three partial products
// through one shared 32x32 multiplier. Raw, top-bit and boolean requests put
// their result word out once the draw is mixed; an empty range or unused kind
// goes straight to the output without a draw.
// A range whose span is not a power of two runs the bit-serial 64-bit
// remainder for each candidate, and a rejected candidate is redrawn; a span
// too wide for the width is redrawn until it falls in range. Either way a
// request makes at most 256 draws.
// The result word sits in an output register, so a new request is taken
// while it waits.
module splitmix_bounded_random_top
  import smbr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,   // range_low, range_high, bit_count, pad
  input  wire logic [2:0]   in_tuser,   // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // value
  output logic              out_tuser   // error
);

  smbr_cmd_t    cmd;
  smbr_status_t st;

  smbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  smbr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_tuser),
    .in_lo      (in_tdata[63:0]),
    .in_hi      (in_tdata[127:64]),
    .in_bits    (in_tdata[133:128]),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_error  (out_tuser)
  );

endmodule
`default_nettype wire
